// ===== rtl/moving_average_speed_scaler_core_defines.svh =====
// ----------------------------------------------------------------------------
// moving average speed scaler assertion macros
// concurrent assertion helpers clocked on i_clk, reset on i_rst_n
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_SPEED_SCALER_CORE_DEFINES_SVH
`define MOVING_AVERAGE_SPEED_SCALER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked outside reset
`define MASS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// implication checked outside reset
`define MASS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MASS_ASSERT(lbl, prop, msg)
`define MASS_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/mass_pkg.sv =====
// ----------------------------------------------------------------------------
// mass_pkg
// shared types and constants of the moving average speed scaler
// ----------------------------------------------------------------------------
package mass_pkg;

    localparam int unsigned SAMPLE_W        = 12;
    localparam int unsigned SPEED_W         = 16;
    localparam int unsigned PROD_W          = SAMPLE_W + SPEED_W;
    localparam int unsigned FULL_SCALE      = 4095;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = 16'd6000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_MUL,
        S_SCALE
    } t_state;

endpackage

// ===== rtl/moving_average_speed_scaler_core.sv =====
// ----------------------------------------------------------------------------
// moving_average_speed_scaler_core
// moving average with warm-up over 12-bit samples, scaled to a speed value
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  sample    in         i_valid / o_ready       i_sample[11:0]
//  result    out        o_valid / i_ready       o_average[11:0], o_speed[15:0]
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_max_speed[15:0]
//
//  path from input beat to result valid: sum update and ring write, 12 restoring
//  divider steps (sum / fill count), multiply, folded divide by 4095
//  one item in flight; the next sample beat is taken only once the last item has left the scale step,
//  even while the result register still waits on i_ready
//  a result stalled on i_ready holds the next item in the scale step until it drains
//  sync active-low reset clears index, fill and sum, sets max_speed to 6000; ring not cleared
// ----------------------------------------------------------------------------
`include "moving_average_speed_scaler_core_defines.svh"

module moving_average_speed_scaler_core #(
    parameter int unsigned WINDOW = 30
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // sample channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mass_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mass_pkg::SAMPLE_W-1:0] o_average,
    output logic [mass_pkg::SPEED_W-1:0]  o_speed,
    // config channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mass_pkg::SPEED_W-1:0]  i_cfg_max_speed
);

    localparam int unsigned QW     = mass_pkg::SAMPLE_W;
    localparam int unsigned IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = $clog2(mass_pkg::FULL_SCALE * WINDOW + 1);
    // divisor shifted by the quotient width always covers the sum
    localparam int unsigned CMP_W  = CNT_W + QW;
    localparam int unsigned STEP_W = $clog2(QW);
    localparam int unsigned PW     = mass_pkg::PROD_W;
    localparam int unsigned SW     = mass_pkg::SPEED_W;

    // state and control
    mass_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]  r_wr_idx;
    logic [CNT_W-1:0]  r_fill;
    logic [SUM_W-1:0]  r_sum;
    logic [SW-1:0]     r_max_speed;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;

    // datapath
    logic [QW-1:0]     r_sample;
    logic [QW-1:0]     r_rd_data;
    logic [SUM_W-1:0]  r_rem;
    logic [CMP_W-1:0]  r_div_sh;
    logic [QW-1:0]     r_quot;
    logic [PW-1:0]     r_prod;
    logic [QW-1:0]     r_average;
    logic [SW-1:0]     r_speed;

    // sample ring, one write and one registered read port
    logic [QW-1:0]     ring [WINDOW];

    logic              w_accept;
    logic              w_full;
    logic              w_out_free;
    logic [SUM_W-1:0]  w_sum_new;
    logic [CNT_W-1:0]  w_fill_new;
    logic [IDX_W-1:0]  w_idx_next;
    logic [CMP_W-1:0]  w_rem_ext;
    logic              w_ge;
    logic [SUM_W-1:0]  w_rem_sub;
    // divide by 4095 through 4096 = 4095 + 1 folding
    logic [SW-1:0]     w_hi;
    logic [SW:0]       w_fold1;
    logic [4:0]        w_hi2;
    logic [QW:0]       w_fold2;
    logic              w_corr;
    logic [SW-1:0]     w_quot_scale;

    assign w_accept   = i_valid && o_ready;
    assign w_full     = (r_fill == CNT_W'(WINDOW));
    assign w_out_free = !r_out_valid || i_ready;

    // running sum update: add new sample, drop oldest once the ring is full
    assign w_sum_new  = r_sum + SUM_W'(r_sample)
                      - (w_full ? SUM_W'(r_rd_data) : '0);
    assign w_fill_new = w_full ? r_fill : r_fill + CNT_W'(1);
    assign w_idx_next = (r_wr_idx == IDX_W'(WINDOW - 1)) ? '0 : r_wr_idx + IDX_W'(1);

    // one restoring divider step
    assign w_rem_ext  = CMP_W'(r_rem);
    assign w_ge       = (w_rem_ext >= r_div_sh);
    assign w_rem_sub  = SUM_W'(w_rem_ext - r_div_sh);

    // product = hi * 4096 + lo -> hi + (hi + lo) / 4095, folded once more
    assign w_hi         = r_prod[PW-1:QW];
    assign w_fold1      = (SW+1)'(w_hi) + (SW+1)'(r_prod[QW-1:0]);
    assign w_hi2        = w_fold1[SW:QW];
    assign w_fold2      = (QW+1)'(w_hi2) + (QW+1)'(w_fold1[QW-1:0]);
    assign w_corr       = (w_fold2 >= (QW+1)'(mass_pkg::FULL_SCALE));
    // never above max_speed, so it fits the speed width
    assign w_quot_scale = w_hi + SW'(w_hi2) + SW'(w_corr);

    // next state and handshake outputs
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            mass_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = mass_pkg::S_UPDATE;
                end
            end
            mass_pkg::S_UPDATE: begin
                n_state = mass_pkg::S_DIV;
            end
            mass_pkg::S_DIV: begin
                if (r_step == STEP_W'(QW - 1)) begin
                    n_state = mass_pkg::S_MUL;
                end
            end
            mass_pkg::S_MUL: begin
                n_state = mass_pkg::S_SCALE;
            end
            mass_pkg::S_SCALE: begin
                if (w_out_free) begin
                    n_state = mass_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mass_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mass_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ring memory: read oldest slot at the input beat, overwrite it with the new sample next cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= ring[r_wr_idx];
        end
        if (r_state == mass_pkg::S_UPDATE) begin
            ring[r_wr_idx] <= r_sample;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_max_speed <= mass_pkg::MAX_SPEED_RESET;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_speed <= i_cfg_max_speed;
            end
            if (r_state == mass_pkg::S_UPDATE) begin
                r_wr_idx <= w_idx_next;
                r_fill   <= w_fill_new;
                r_sum    <= w_sum_new;
                r_step   <= '0;
            end else if (r_state == mass_pkg::S_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (r_state == mass_pkg::S_SCALE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
        end
        unique case (r_state)
            mass_pkg::S_UPDATE: begin
                r_rem    <= w_sum_new;
                r_div_sh <= CMP_W'(w_fill_new) << (QW - 1);
            end
            mass_pkg::S_DIV: begin
                r_quot   <= {r_quot[QW-2:0], w_ge};
                r_div_sh <= r_div_sh >> 1;
                if (w_ge) begin
                    r_rem <= w_rem_sub;
                end
            end
            mass_pkg::S_MUL: begin
                r_prod <= PW'(r_quot) * PW'(r_max_speed);
            end
            mass_pkg::S_SCALE: begin
                if (w_out_free) begin
                    r_average <= r_quot;
                    r_speed   <= w_quot_scale;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_average   = r_average;
    assign o_speed     = r_speed;
    assign o_cfg_ready = 1'b1;

    // checks
    `MASS_ASSERT(a_fill_in_range, r_fill <= CNT_W'(WINDOW), "fill count beyond window")
    `MASS_ASSERT(a_idx_in_range, r_wr_idx <= IDX_W'(WINDOW - 1), "write index beyond ring")
    `MASS_ASSERT(a_div_nonzero, (r_state != mass_pkg::S_DIV) || (r_fill != '0), "zero divisor")
    `MASS_ASSERT_IMPL(a_accept_update, w_accept, r_state == mass_pkg::S_UPDATE, "no update")
    `MASS_ASSERT_IMPL(a_scale_load, (r_state == mass_pkg::S_SCALE) && w_out_free, o_valid, "no result")

endmodule
